FILE: rtl/core/r2y420_pkg.sv
// Shared types and constants for the RGB to YCbCr 4:2:0 converter.
`timescale 1ns / 1ps

package r2y420_pkg;

	// Configuration register indexes.
	localparam logic REG_HALF_WIDTH  = 1'b0;
	localparam logic REG_HALF_HEIGHT = 1'b1;

	// Configuration register reset values.
	localparam logic [10:0] HALF_WIDTH_RST  = 11'd320;
	localparam logic [10:0] HALF_HEIGHT_RST = 11'd240;

	// Width used to compare positions against the saturated frame size.
	localparam int unsigned SIZE_W = 13;

	// Color arithmetic width; every weighted sum stays below 2^16.
	localparam int unsigned ACC_W = 17;

	// BT.601 limited-range weights (magnitudes; signs are applied in the datapath).
	localparam logic [16:0] Y_R  = 17'd66;
	localparam logic [16:0] Y_G  = 17'd129;
	localparam logic [16:0] Y_B  = 17'd25;
	localparam logic [16:0] CB_R = 17'd38;
	localparam logic [16:0] CB_G = 17'd74;
	localparam logic [16:0] CB_B = 17'd112;
	localparam logic [16:0] CR_R = 17'd112;
	localparam logic [16:0] CR_G = 17'd94;
	localparam logic [16:0] CR_B = 17'd18;

	// Rounding term, and rounding plus the 128 offset moved ahead of the shift.
	localparam logic [16:0] ROUND_TERM  = 17'd128;
	localparam logic [16:0] CHROMA_BIAS = 17'd32896;
	localparam logic [7:0]  LUMA_OFS    = 8'd16;

	// Per-pixel control that travels alongside the pixel data.
	typedef struct packed {
		logic second_px;   // right pixel of a column pair
		logic odd_row;     // lower row of a 2x2 block
		logic frame_end;   // last pixel of the frame
	} pix_ctrl_t;

endpackage

FILE: rtl/core/rgb_to_yuv420_converter.sv
// RGB888 to BT.601 limited-range YCbCr 4:2:0 converter, top level.
// An input pixel passes the stage 1, stage 2 and output registers before it can transfer out.
// One pixel per cycle unless the output stalls; a stage holds only while the next is full.
// The line buffer takes one write and one registered read per cycle, set by its single port pair.
// Reset clears the raster position, the pipeline valid bits and sets the size registers
// to 320 x 240 half units. The line buffer is not cleared and needs no clearing pass.
`timescale 1ns / 1ps

module rgb_to_yuv420_converter #(
	parameter int MAX_HALF_WIDTH  = 1024,
	parameter int MAX_HALF_HEIGHT = 1024
) (
	input  logic        clk,
	input  logic        arst_n,
	// Configuration write port.
	input  logic        wr_en,
	input  logic        wr_index,
	input  logic [10:0] wr_data,
	// Pixel input stream.
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [23:0] s_axis_tdata,    // red [7:0], green [15:8], blue [23:16]
	// YCbCr output stream.
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [23:0] m_axis_tdata,    // luma [7:0], cb_avg [15:8], cr_avg [23:16]
	output logic        m_axis_tuser,    // chroma_valid [0]
	output logic        m_axis_tlast     // frame_end
);

	import r2y420_pkg::*;

	localparam int CW = (MAX_HALF_WIDTH > 1) ? $clog2(MAX_HALF_WIDTH) : 1;
	localparam int RW = (MAX_HALF_HEIGHT > 1) ? $clog2(MAX_HALF_HEIGHT) : 1;

	// Configuration registers.
	logic [10:0] half_width_q;
	logic [10:0] half_height_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			half_width_q  <= HALF_WIDTH_RST;
			half_height_q <= HALF_HEIGHT_RST;
		end else if (wr_en) begin
			case (wr_index)
				REG_HALF_WIDTH:  half_width_q  <= wr_data;
				REG_HALF_HEIGHT: half_height_q <= wr_data;
				default:         half_width_q  <= half_width_q;
			endcase
		end
	end

	// Last column and row positions, with the sizes saturated into their legal range.
	logic [SIZE_W-1:0] col_last;
	logic [SIZE_W-1:0] row_last;

	always_comb begin
		if (half_width_q == '0) begin
			col_last = '0;
		end else if (SIZE_W'(half_width_q) > SIZE_W'(MAX_HALF_WIDTH)) begin
			col_last = SIZE_W'(MAX_HALF_WIDTH - 1);
		end else begin
			col_last = SIZE_W'(half_width_q) - SIZE_W'(1);
		end
		if (half_height_q == '0) begin
			row_last = '0;
		end else if (SIZE_W'(half_height_q) > SIZE_W'(MAX_HALF_HEIGHT)) begin
			row_last = SIZE_W'(MAX_HALF_HEIGHT - 1);
		end else begin
			row_last = SIZE_W'(half_height_q) - SIZE_W'(1);
		end
	end

	// Stage handshakes: a stage advances when it is empty or the next stage takes its item.
	logic v_s1, v_s2, out_v_q;
	logic adv_out, adv_s2, adv_s1;
	logic in_xfer;

	assign adv_out       = !out_v_q || m_axis_tready;
	assign adv_s2        = !v_s2 || adv_out;
	assign adv_s1        = !v_s1 || adv_s2;
	assign s_axis_tready = adv_s1;
	assign in_xfer       = s_axis_tvalid && s_axis_tready;

	// Raster position, advanced on each input transfer.
	logic [CW-1:0] col_q;
	logic [RW-1:0] row_q;
	logic          pip_q;
	logic          odd_q;
	logic          at_last_col;
	logic          at_last_row;

	assign at_last_col = SIZE_W'(col_q) >= col_last;
	assign at_last_row = SIZE_W'(row_q) >= row_last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
			pip_q <= 1'b0;
			odd_q <= 1'b0;
		end else if (in_xfer) begin
			pip_q <= !pip_q;
			if (pip_q) begin
				if (!at_last_col) begin
					col_q <= col_q + CW'(1);
				end else begin
					col_q <= '0;
					odd_q <= !odd_q;
					if (odd_q) begin
						row_q <= at_last_row ? '0 : row_q + RW'(1);
					end
				end
			end
		end
	end

	// Stage 1: registered pixel, its column and its control flags.
	logic [7:0]    red_s1, green_s1, blue_s1;
	logic [CW-1:0] col_s1;
	pix_ctrl_t     ctrl_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (adv_s1) begin
			v_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			red_s1              <= s_axis_tdata[7:0];
			green_s1            <= s_axis_tdata[15:8];
			blue_s1             <= s_axis_tdata[23:16];
			col_s1              <= col_q;
			ctrl_s1.second_px   <= pip_q;
			ctrl_s1.odd_row     <= odd_q;
			ctrl_s1.frame_end   <= pip_q && odd_q && at_last_col && at_last_row;
		end
	end

	// Per-pixel luma and chroma; chroma carries the 128 offset before the floor shift.
	logic [ACC_W-1:0] y_acc, cb_acc, cr_acc;
	logic [ACC_W-1:0] r_ext, g_ext, b_ext;

	assign r_ext  = ACC_W'(red_s1);
	assign g_ext  = ACC_W'(green_s1);
	assign b_ext  = ACC_W'(blue_s1);
	assign y_acc  = Y_R * r_ext + Y_G * g_ext + Y_B * b_ext + ROUND_TERM;
	assign cb_acc = CHROMA_BIAS + CB_B * b_ext - CB_R * r_ext - CB_G * g_ext;
	assign cr_acc = CHROMA_BIAS + CR_R * r_ext - CR_G * g_ext - CR_B * b_ext;

	// Stage 2: color results and the line buffer read for the same column.
	logic [7:0]    luma_s2, cb_s2, cr_s2;
	logic [CW-1:0] col_s2;
	pix_ctrl_t     ctrl_s2;
	logic [17:0]   upper_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (adv_s2) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s2 && v_s1) begin
			luma_s2 <= y_acc[15:8] + LUMA_OFS;
			cb_s2   <= cb_acc[15:8];
			cr_s2   <= cr_acc[15:8];
			col_s2  <= col_s1;
			ctrl_s2 <= ctrl_s1;
		end
	end

	// Line buffer of upper-row pair sums: Cb sum in [17:9], Cr sum in [8:0].
	logic [17:0] line_mem [MAX_HALF_WIDTH];
	logic        mem_we;
	logic [8:0]  sum_cb, sum_cr;

	always_ff @(posedge clk) begin
		if (adv_s2 && v_s1) begin
			upper_s2 <= line_mem[col_s1];
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			line_mem[col_s2] <= {sum_cb, sum_cr};
		end
	end

	// Horizontal pair sums; the left pixel of a pair starts a new sum.
	logic [8:0] pair_cb_q, pair_cr_q;

	assign sum_cb = pair_cb_q + 9'(cb_s2);
	assign sum_cr = pair_cr_q + 9'(cr_s2);
	assign mem_we = adv_out && v_s2 && ctrl_s2.second_px && !ctrl_s2.odd_row;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pair_cb_q <= '0;
			pair_cr_q <= '0;
		end else if (adv_out && v_s2) begin
			if (ctrl_s2.second_px) begin
				pair_cb_q <= sum_cb;
				pair_cr_q <= sum_cr;
			end else begin
				pair_cb_q <= 9'(cb_s2);
				pair_cr_q <= 9'(cr_s2);
			end
		end
	end

	// Block totals; a quarter of a total of four 16..240 values needs no clamp.
	logic [9:0] tot_cb, tot_cr;
	logic       blk_done;

	assign tot_cb   = 10'(sum_cb) + 10'(upper_s2[17:9]);
	assign tot_cr   = 10'(sum_cr) + 10'(upper_s2[8:0]);
	assign blk_done = ctrl_s2.second_px && ctrl_s2.odd_row;

	// Output register.
	logic [7:0] luma_q, cb_avg_q, cr_avg_q;
	logic       cvalid_q, fend_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (adv_out) begin
			out_v_q <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_out && v_s2) begin
			luma_q   <= luma_s2;
			cvalid_q <= blk_done;
			cb_avg_q <= blk_done ? tot_cb[9:2] : '0;
			cr_avg_q <= blk_done ? tot_cr[9:2] : '0;
			fend_q   <= ctrl_s2.frame_end;
		end
	end

	assign m_axis_tvalid = out_v_q;
	assign m_axis_tdata  = {cr_avg_q, cb_avg_q, luma_q};
	assign m_axis_tuser  = cvalid_q;
	assign m_axis_tlast  = fend_q;

endmodule

FILE: rtl/core/r2y420_checker.sv
// Port-level assertions for the RGB to YCbCr 4:2:0 converter, with its bind.
`timescale 1ns / 1ps

module r2y420_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [23:0] m_axis_tdata,
	input logic        m_axis_tuser,
	input logic        m_axis_tlast
);

	// A frame ends only on a pixel that completes a chroma block.
	a_last_has_chroma: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tlast |-> m_axis_tuser)
		else $error("frame end without chroma");

	// Without chroma the averaged fields read as zero.
	a_no_chroma_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata[23:8] == 16'd0)
		else $error("chroma fields set without chroma_valid");

	// Luma stays within the limited range.
	a_luma_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> m_axis_tdata[7:0] >= 8'd16 && m_axis_tdata[7:0] <= 8'd235)
		else $error("luma out of range");

	// Averaged chroma stays within the limited range.
	a_chroma_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser |->
			m_axis_tdata[15:8] >= 8'd16 && m_axis_tdata[15:8] <= 8'd240 &&
			m_axis_tdata[23:16] >= 8'd16 && m_axis_tdata[23:16] <= 8'd240)
		else $error("chroma out of range");

	// A stalled result holds until its transfer.
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=>
			m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser) &&
			$stable(m_axis_tlast))
		else $error("stalled result changed");

endmodule

bind rgb_to_yuv420_converter r2y420_checker u_r2y420_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata),
	.m_axis_tuser  (m_axis_tuser),
	.m_axis_tlast  (m_axis_tlast)
);

FILE: dv/yuv420_checker.sv
// Scoreboard for the RGB to YCbCr 4:2:0 converter: predicts every output transfer and checks it.
`timescale 1ns / 1ps

module yuv420_checker #(
	parameter int MAX_HALF_WIDTH  = 1024,
	parameter int MAX_HALF_HEIGHT = 1024
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        wr_en,
	input  logic        wr_index,
	input  logic [10:0] wr_data,
	input  logic        s_axis_tvalid,
	input  logic        s_axis_tready,
	input  logic [23:0] s_axis_tdata,    // red [7:0], green [15:8], blue [23:16]
	input  logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	input  logic [23:0] m_axis_tdata,    // luma [7:0], cb_avg [15:8], cr_avg [23:16]
	input  logic        m_axis_tuser,    // chroma_valid [0]
	input  logic        m_axis_tlast,    // frame_end
	output int          fail_count,
	output int          pending,
	output logic        odd_row_now
);

	import r2y420_pkg::*;

	// BT.601 limited-range weights and offsets.
	localparam int WY_R  = 66;
	localparam int WY_G  = 129;
	localparam int WY_B  = 25;
	localparam int WCB_R = -38;
	localparam int WCB_G = -74;
	localparam int WCB_B = 112;
	localparam int WCR_R = 112;
	localparam int WCR_G = -94;
	localparam int WCR_B = -18;
	localparam int ROUND = 128;
	localparam int Y_OFS = 16;
	// Moves the +128 chroma offset ahead of the shift so the floor works on a positive sum.
	localparam int C_BIAS = 32768;
	localparam int MAX_REPORTS = 10;

	typedef struct packed {
		logic [7:0] luma;
		logic       chroma_valid;
		logic [7:0] cb_avg;
		logic [7:0] cr_avg;
		logic       frame_end;
	} yuv_px_t;

	// Shadow of the size registers.
	logic [10:0] half_width_q;
	logic [10:0] half_height_q;

	// Raster position and running chroma sums.
	int unsigned col_pair;
	logic        second_px;
	int unsigned row_pair;
	logic        odd_row;
	logic [8:0]  acc_cb;
	logic [8:0]  acc_cr;
	logic [8:0]  upper_cb [MAX_HALF_WIDTH];
	logic [8:0]  upper_cr [MAX_HALF_WIDTH];

	yuv_px_t expected_yuv [$];

	// Size register saturated into 1..max.
	function automatic int unsigned clip_size(input logic [10:0] v, input int unsigned max_v);
		if (v == 11'd0) return 1;
		if (v > max_v) return max_v;
		return v;
	endfunction

	function automatic logic [7:0] clamp_byte(input int v);
		if (v < 0) return 8'd0;
		if (v > 255) return 8'd255;
		return v[7:0];
	endfunction

	// Converts one pixel and moves the raster position on.
	function automatic yuv_px_t convert_pixel(input logic [23:0] px);
		int          ri, gi, bi, tcb, tcr;
		int unsigned hw, hh;
		logic [8:0]  cb_px, cr_px, sum_cb, sum_cr;
		logic        last_col, last_row;
		yuv_px_t     o;
		ri = px[7:0];
		gi = px[15:8];
		bi = px[23:16];
		hw = clip_size(half_width_q, MAX_HALF_WIDTH);
		hh = clip_size(half_height_q, MAX_HALF_HEIGHT);
		o = '0;
		// All sums below are non-negative, so division is a floor shift.
		o.luma = clamp_byte((WY_R * ri + WY_G * gi + WY_B * bi + ROUND) / 256 + Y_OFS);
		cb_px = 9'((WCB_R * ri + WCB_G * gi + WCB_B * bi + ROUND + C_BIAS) / 256);
		cr_px = 9'((WCR_R * ri + WCR_G * gi + WCR_B * bi + ROUND + C_BIAS) / 256);
		last_col = (col_pair >= hw - 1);
		last_row = (row_pair >= hh - 1);

		// Pair sums: even rows feed the line buffer, odd rows complete the block.
		if (!second_px) begin
			acc_cb = cb_px;
			acc_cr = cr_px;
		end else begin
			sum_cb = acc_cb + cb_px;
			sum_cr = acc_cr + cr_px;
			if (!odd_row) begin
				upper_cb[col_pair] = sum_cb;
				upper_cr[col_pair] = sum_cr;
			end else begin
				tcb = sum_cb + upper_cb[col_pair];
				tcr = sum_cr + upper_cr[col_pair];
				o.chroma_valid = 1'b1;
				o.cb_avg = clamp_byte(tcb / 4);
				o.cr_avg = clamp_byte(tcr / 4);
				o.frame_end = last_col && last_row;
			end
			acc_cb = sum_cb;
			acc_cr = sum_cr;
		end

		// Raster advance; counters past the end wrap at the end of the pair.
		if (!second_px) begin
			second_px = 1'b1;
		end else begin
			second_px = 1'b0;
			if (!last_col) begin
				col_pair = col_pair + 1;
			end else begin
				col_pair = 0;
				if (!odd_row) begin
					odd_row = 1'b1;
				end else begin
					odd_row = 1'b0;
					row_pair = last_row ? 0 : row_pair + 1;
				end
			end
		end
		return o;
	endfunction

	// Watch the three ports, predict on each input transfer, compare on each output transfer.
	always @(posedge clk or negedge arst_n) begin
		yuv_px_t got, want;
		if (!arst_n) begin
			half_width_q = HALF_WIDTH_RST;
			half_height_q = HALF_HEIGHT_RST;
			col_pair = 0;
			second_px = 1'b0;
			row_pair = 0;
			odd_row = 1'b0;
			acc_cb = '0;
			acc_cr = '0;
			expected_yuv.delete();
			fail_count = 0;
		end else begin
			if (s_axis_tvalid && s_axis_tready)
				expected_yuv.push_back(convert_pixel(s_axis_tdata));
			if (m_axis_tvalid && m_axis_tready) begin
				got.luma = m_axis_tdata[7:0];
				got.chroma_valid = m_axis_tuser;
				got.cb_avg = m_axis_tdata[15:8];
				got.cr_avg = m_axis_tdata[23:16];
				got.frame_end = m_axis_tlast;
				if (expected_yuv.size() == 0) begin
					fail_count++;
					if (fail_count <= MAX_REPORTS)
						$display("%0t: output transfer with nothing expected: luma %0d cv %0b",
							$realtime, got.luma, got.chroma_valid);
				end else begin
					want = expected_yuv.pop_front();
					if (got != want) begin
						fail_count++;
						if (fail_count <= MAX_REPORTS)
							$display("%0t: exp/got y %0d/%0d cv %0b/%0b cb %0d/%0d %s",
								$realtime, want.luma, got.luma, want.chroma_valid,
								got.chroma_valid, want.cb_avg, got.cb_avg,
								$sformatf("cr %0d/%0d end %0b/%0b", want.cr_avg,
								got.cr_avg, want.frame_end, got.frame_end));
					end
				end
			end
			// A register write takes effect for pixels accepted after this edge.
			if (wr_en) begin
				if (wr_index == REG_HALF_WIDTH)
					half_width_q = wr_data;
				else
					half_height_q = wr_data;
			end
		end
		pending = expected_yuv.size();
		odd_row_now = odd_row;
	end

endmodule

FILE: dv/testbench.sv
// Top of the converter testbench: clock, reset, pixel stimulus, output back-pressure and verdict.
`timescale 1ns / 1ps

module testbench;
	import r2y420_pkg::*;

	localparam int CYCLE_LIMIT = 300000;
	localparam int LATENCY     = 3;
	localparam int HOLD_CYCLES = 300;
	localparam int PHASE_ITEMS = 113;

	typedef enum int {
		PH_DIRECTED,
		PH_STEADY,
		PH_SEND_IDLE,
		PH_RECV_STALL,
		PH_BOTH,
		PH_PRESSURE
	} phase_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        wr_en = 1'b0;
	logic        wr_index = REG_HALF_WIDTH;
	logic [10:0] wr_data = '0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [23:0] s_axis_tdata = '0;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [23:0] m_axis_tdata;
	logic        m_axis_tuser;
	logic        m_axis_tlast;

	int          fail_count;
	int          pending;
	logic        odd_row_now;
	int          cycle_count = 0;
	int          send_idle_pct = 0;
	int          stall_pct = 0;
	int          hold_left = -1;
	phase_t      phase = PH_DIRECTED;
	logic [10:0] cur_hw = HALF_WIDTH_RST;

	always #5 clk = ~clk;

	rgb_to_yuv420_converter dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.wr_en         (wr_en),
		.wr_index      (wr_index),
		.wr_data       (wr_data),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast)
	);

	yuv420_checker u_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.wr_en         (wr_en),
		.wr_index      (wr_index),
		.wr_data       (wr_data),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast),
		.fail_count    (fail_count),
		.pending       (pending),
		.odd_row_now   (odd_row_now)
	);

	// Watchdog on the whole run.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	// Output back-pressure; the pressure phase opens with one long hold-off.
	always @(negedge clk) begin
		if (phase == PH_PRESSURE && hold_left < 0)
			hold_left = HOLD_CYCLES;
		if (hold_left > 0) begin
			hold_left = hold_left - 1;
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= ($urandom_range(0, 99) >= stall_pct);
		end
	end

	// Component biased toward its extremes.
	function automatic logic [7:0] pick_component();
		case ($urandom_range(0, 7))
			0: return 8'h00;
			1: return 8'hFF;
			default: return 8'($urandom_range(0, 255));
		endcase
	endfunction

	function automatic logic [23:0] random_pixel();
		return {pick_component(), pick_component(), pick_component()};
	endfunction

	// One pixel transfer, with random idle cycles ahead of it. Starts and ends at a falling edge.
	task automatic send_pixel(input logic [23:0] px);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= px;
		do @(posedge clk); while (!s_axis_tready);
		@(negedge clk);
	endtask

	task automatic send_rgb(input logic [7:0] r, input logic [7:0] g, input logic [7:0] b);
		send_pixel({b, g, r});
	endtask

	// Stop offering pixels and wait until every expected output has come out.
	task automatic wait_idle();
		s_axis_tvalid <= 1'b0;
		while (pending != 0) @(negedge clk);
		repeat (LATENCY + 1) @(negedge clk);
	endtask

	task automatic write_reg(input logic idx, input logic [10:0] value);
		wr_en <= 1'b1;
		wr_index <= idx;
		wr_data <= value;
		@(negedge clk);
		wr_en <= 1'b0;
		@(negedge clk);
		if (idx == REG_HALF_WIDTH)
			cur_hw = value;
	endtask

	// New sizes while idle. Height may change anywhere. Width may grow only on an even row,
	// so that an odd row never reads a line buffer entry that was not written this row pair.
	task automatic retune();
		logic [10:0] eff_hw;
		eff_hw = (cur_hw == 11'd0) ? 11'd1 : cur_hw;
		if ($urandom_range(0, 1))
			write_reg(REG_HALF_HEIGHT, 11'($urandom_range(0, 4)));
		if ($urandom_range(0, 1)) begin
			if (odd_row_now)
				write_reg(REG_HALF_WIDTH, 11'($urandom_range(0, eff_hw)));
			else
				write_reg(REG_HALF_WIDTH, 11'($urandom_range(0, 6)));
		end
	endtask

	task automatic run_phase(input phase_t ph, input int idle_pct, input int stall,
		input int items);
		int sent;
		int len;
		phase = ph;
		send_idle_pct = idle_pct;
		stall_pct = stall;
		sent = 0;
		while (sent < items) begin
			len = $urandom_range(1, 48);
			if (len > items - sent)
				len = items - sent;
			repeat (len) send_pixel(random_pixel());
			sent += len;
			if ($urandom_range(0, 2) == 0) begin
				wait_idle();
				retune();
			end
		end
		wait_idle();
	endtask

	initial begin
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Start at the reset size, then narrow mid-row so the row ends after the current pair.
		send_rgb(8'h00, 8'h00, 8'hFF);
		send_rgb(8'h00, 8'h00, 8'hFF);
		send_rgb(8'h00, 8'h00, 8'h00);
		send_rgb(8'hFF, 8'hFF, 8'hFF);
		wait_idle();
		write_reg(REG_HALF_WIDTH, 11'd1);
		write_reg(REG_HALF_HEIGHT, 11'd0);
		send_rgb(8'hFF, 8'h00, 8'h00);
		send_rgb(8'h00, 8'hFF, 8'h00);
		send_rgb(8'h00, 8'h00, 8'hFF);
		send_rgb(8'h00, 8'h00, 8'hFF);
		wait_idle();

		// Width above the maximum saturates; narrowing later wraps the row early.
		write_reg(REG_HALF_WIDTH, 11'd1025);
		repeat (3) send_rgb(8'hFF, 8'h00, 8'h00);
		send_rgb(8'h00, 8'hFF, 8'h00);
		send_rgb(8'hFF, 8'hFF, 8'h00);
		send_rgb(8'h00, 8'h00, 8'h00);
		wait_idle();
		write_reg(REG_HALF_WIDTH, 11'd2);
		send_rgb(8'hFF, 8'h00, 8'hFF);
		send_rgb(8'h00, 8'hFF, 8'hFF);
		repeat (4) send_rgb(8'hFF, 8'h00, 8'h00);
		wait_idle();

		// Largest sizes for part of a row, then a narrow frame whose lower row reads it back.
		write_reg(REG_HALF_WIDTH, 11'd2047);
		write_reg(REG_HALF_HEIGHT, 11'd2047);
		repeat (8) send_pixel(random_pixel());
		wait_idle();
		write_reg(REG_HALF_WIDTH, 11'd4);
		write_reg(REG_HALF_HEIGHT, 11'd0);
		repeat (10) send_pixel(random_pixel());
		wait_idle();

		run_phase(PH_STEADY, 0, 0, PHASE_ITEMS);
		run_phase(PH_SEND_IDLE, 73, 0, PHASE_ITEMS);
		run_phase(PH_RECV_STALL, 0, 73, PHASE_ITEMS);
		run_phase(PH_BOTH, 7, 7, PHASE_ITEMS);
		run_phase(PH_PRESSURE, 0, 0, 60);

		repeat (4 * LATENCY) @(negedge clk);
		if (fail_count == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
